[hw/rtl/bb3c_pkg.sv]
// Shared types, widths and the reciprocal table of the clipped 3x3 box filter.
package bb3c_pkg;

    localparam int CH_W      = 16;  // one colour channel
    localparam int NUM_CH    = 3;   // red, green, blue
    localparam int DIM_W     = 11;  // frame dimension and row/column counters
    localparam int COLSUM_W  = 18;  // sum of up to three channel values
    localparam int SUM_W     = 20;  // sum of up to nine channel values
    localparam int CNT_W     = 4;   // neighbourhood size, 1 to 9
    localparam int RECIP_SH  = 24;  // fixed-point shift of the reciprocals
    localparam int RECIP_W   = 25;  // holds 2^RECIP_SH for a count of one
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(512);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // channel 0 is red, 1 green, 2 blue; red sits in the lowest bits
    typedef logic [NUM_CH-1:0][CH_W-1:0]     t_pix;
    typedef logic [NUM_CH-1:0][COLSUM_W-1:0] t_colsum;
    typedef logic [NUM_CH-1:0][SUM_W-1:0]    t_sum;

    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_line;

    // per-item control travelling beside the pixel
    typedef struct packed {
        logic             valid;
        logic             drain;
        logic             top_ok;
        logic             bot_ok;
        logic             a_en;      // mean centred one column back
        logic             a_left;
        logic             b_en;      // mean centred on the last column
        logic             b_left;
        logic             frame_end;
        logic [CNT_W-1:0] a_cnt;
        logic [CNT_W-1:0] b_cnt;
    } t_ctl;

    // window sums and reciprocals handed to the divider stage
    typedef struct packed {
        logic               a_en;
        logic               b_en;
        logic               frame_end;
        t_sum               sum_a;
        t_sum               sum_b;
        logic [RECIP_W-1:0] rcp_a;
        logic [RECIP_W-1:0] rcp_b;
    } t_div_in;

    // ceil(2^24 / n): exact floor division for every sum below 2^20
    function automatic logic [RECIP_W-1:0] f_recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd2:    r = RECIP_W'(8388608);
            4'd3:    r = RECIP_W'(5592406);
            4'd4:    r = RECIP_W'(4194304);
            4'd6:    r = RECIP_W'(2796203);
            4'd9:    r = RECIP_W'(1864136);
            default: r = RECIP_W'(16777216);
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/box_blur_3x3_clipped.sv]
// A result is registered in turn in the control, column-sum, window-sum and output registers.
// Throughput: one input transaction per cycle while the output is not stalled; an item that
// gives two results holds the input side while the first leaves. The rate is set by the single read
// and single write port of the line store, one column per cycle.
// Reset (synchronous, active low) clears counters, pipe valids and the output register and
// sets the dimension to 512; line store contents are left as they are.
module box_blur_3x3_clipped
    import bb3c_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [DIM_W-1:0] i_cfg_wr_data,  // image_dim
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [47:0]      s_axis_tdata,   // red_in [15:0], green_in [31:16], blue_in [47:32]
    input  logic [0:0]       s_axis_tuser,   // op [0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // red_out [15:0], green_out [31:16], blue_out [47:32]
    output logic             m_axis_tlast,   // frame_end
    output logic [0:0]       m_axis_tuser    // run_last [0]
);

    localparam int AW = $clog2(MAX_DIM);

    // whole pipe advances together whenever the output register can take a new pair
    logic          en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] s1_addr;
    t_ctl          s1_ctl;
    t_pix          s1_px;
    t_line         line_rd;
    t_line         line_wr;
    logic          line_wr_en;
    t_div_in       div_in;
    t_pix          out_px;
    logic          out_fe;
    logic          out_last;

    assign s_axis_tready = en;

    // stage 0: count rows and columns, decode which means the item releases
    bb3c_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_in_valid    (s_axis_tvalid),
        .i_op          (s_axis_tuser[0]),
        .i_px          (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_rd_addr     (rd_addr),
        .o_ctl         (s1_ctl),
        .o_px          (s1_px),
        .o_addr        (s1_addr)
    );

    // stage 1: the column read comes back; push middle up and the new pixel into middle
    assign line_wr_en     = en && s1_ctl.valid && !s1_ctl.drain;
    assign line_wr.upper  = line_rd.middle;
    assign line_wr.middle = s1_px;

    bb3c_line_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (line_wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (line_wr),
        .o_rd_data (line_rd)
    );

    // stages 1 and 2: column sums into the window, then clipped window sums
    bb3c_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (s1_ctl),
        .i_px    (s1_px),
        .i_line  (line_rd),
        .o_div   (div_in)
    );

    // stage 3: divide by the neighbourhood size and hold up to two results
    bb3c_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_div       (div_in),
        .i_ready     (m_axis_tready),
        .o_en        (en),
        .o_valid     (m_axis_tvalid),
        .o_px        (out_px),
        .o_frame_end (out_fe),
        .o_run_last  (out_last)
    );

    assign m_axis_tdata    = out_px;
    assign m_axis_tlast    = out_fe;
    assign m_axis_tuser[0] = out_last;

endmodule

[hw/rtl/bb3c_ctrl.sv]
// Row and column counters, frame dimension register and per-item control decode.
module bb3c_ctrl
    import bb3c_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_in_valid,
    input  logic                       i_op,
    input  t_pix                       i_px,
    input  logic                       i_cfg_wr_en,
    input  logic [DIM_W-1:0]           i_cfg_wr_data,
    output logic [$clog2(MAX_DIM)-1:0] o_rd_addr,
    output t_ctl                       o_ctl,
    output t_pix                       o_px,
    output logic [$clog2(MAX_DIM)-1:0] o_addr
);

    localparam int AW = $clog2(MAX_DIM);

    function automatic logic [DIM_W-1:0] f_eff_dim(input logic [DIM_W-1:0] raw);
        logic [DIM_W-1:0] d;
        if (raw == '0) begin
            d = DIM_W'(1);
        end else if (int'(raw) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = raw;
        end
        return d;
    endfunction

    logic [DIM_W-1:0] r_dim;
    logic [DIM_W-1:0] r_row;
    logic [DIM_W-1:0] r_col;
    t_ctl             r_ctl;
    t_pix             r_px;
    logic [AW-1:0]    r_addr;

    logic [DIM_W-1:0] col_inc;
    logic             draining;
    logic             step;
    logic             last_col;
    logic [1:0]       nrow;
    logic [1:0]       a_ncol;
    logic [1:0]       b_ncol;
    t_ctl             n_ctl;

    always_comb begin
        col_inc  = r_col + DIM_W'(1);
        draining = (r_row >= r_dim);
        last_col = (col_inc >= r_dim);
        // a drain tick inside the frame or a pixel while draining is dropped
        step     = i_en && i_in_valid && ((i_op == OP_DRAIN) == draining);

        n_ctl.valid     = step;
        n_ctl.drain     = draining;
        n_ctl.top_ok    = (r_row >= DIM_W'(2));
        n_ctl.bot_ok    = !draining;
        n_ctl.a_en      = (r_row != '0) && (r_col != '0);
        n_ctl.a_left    = (r_col >= DIM_W'(2));
        n_ctl.b_en      = (r_row != '0) && (col_inc == r_dim);
        n_ctl.b_left    = (r_col != '0);
        n_ctl.frame_end = draining;

        nrow   = 2'd1 + 2'(n_ctl.top_ok) + 2'(n_ctl.bot_ok);
        a_ncol = 2'd2 + 2'(n_ctl.a_left);
        b_ncol = 2'd1 + 2'(n_ctl.b_left);
        n_ctl.a_cnt = CNT_W'(nrow) * CNT_W'(a_ncol);
        n_ctl.b_cnt = CNT_W'(nrow) * CNT_W'(b_ncol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= f_eff_dim(DIM_RST);
            r_row <= '0;
            r_col <= '0;
            r_ctl <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dim <= f_eff_dim(i_cfg_wr_data);
                r_row <= '0;
                r_col <= '0;
            end else if (step) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= draining ? '0 : r_row + DIM_W'(1);
                end else begin
                    r_col <= col_inc;
                end
            end
            if (i_en) begin
                r_ctl <= n_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= (i_op == OP_DRAIN) ? '0 : i_px;
            r_addr <= AW'(r_col);
        end
    end

    assign o_rd_addr = AW'(r_col);
    assign o_ctl     = r_ctl;
    assign o_px      = r_px;
    assign o_addr    = r_addr;

endmodule

[hw/rtl/bb3c_line_mem.sv]
// Two line stores in one synchronous memory, one read and one write port, with bypass.
module bb3c_line_mem
    import bb3c_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [$clog2(MAX_DIM)-1:0] i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [$clog2(MAX_DIM)-1:0] i_wr_addr,
    input  t_line                      i_wr_data,
    output t_line                      o_rd_data
);

    t_line r_mem [MAX_DIM];
    t_line r_rd;
    t_line r_fwd_data;
    logic  r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // a write landing on the entry read at the same edge bypasses the old data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd;

endmodule

[hw/rtl/bb3c_window.sv]
// Column sums of the 3x3 window and the clipped window sums for both means.
module bb3c_window
    import bb3c_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_ctl    i_ctl,
    input  t_pix    i_px,
    input  t_line   i_line,
    output t_div_in o_div
);

    t_colsum r_cs [3];
    t_ctl    r_ctl2;
    t_div_in r_div;

    t_colsum new_col;
    t_div_in n_div;

    // clip top and bottom rows per column; columns of one mean share a row
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            new_col[k] = COLSUM_W'(i_line.middle[k])
                       + (i_ctl.top_ok ? COLSUM_W'(i_line.upper[k]) : '0)
                       + (i_ctl.bot_ok ? COLSUM_W'(i_px[k]) : '0);
        end
    end

    always_comb begin
        n_div.a_en      = r_ctl2.valid && r_ctl2.a_en;
        n_div.b_en      = r_ctl2.valid && r_ctl2.b_en;
        n_div.frame_end = r_ctl2.frame_end;
        n_div.rcp_a     = f_recip(r_ctl2.a_cnt);
        n_div.rcp_b     = f_recip(r_ctl2.b_cnt);
        for (int k = 0; k < NUM_CH; k++) begin
            n_div.sum_a[k] = (r_ctl2.a_left ? SUM_W'(r_cs[0][k]) : '0)
                           + SUM_W'(r_cs[1][k]) + SUM_W'(r_cs[2][k]);
            n_div.sum_b[k] = (r_ctl2.b_left ? SUM_W'(r_cs[1][k]) : '0)
                           + SUM_W'(r_cs[2][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.valid) begin
            r_cs[0] <= r_cs[1];
            r_cs[1] <= r_cs[2];
            r_cs[2] <= new_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_div  <= '0;
        end else if (i_en) begin
            r_ctl2 <= i_ctl;
            r_div  <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

[hw/rtl/bb3c_out.sv]
// Reciprocal multiply per channel and the two-entry result register on the output side.
module bb3c_out
    import bb3c_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_div_in i_div,
    input  logic    i_ready,
    output logic    o_en,
    output logic    o_valid,
    output t_pix    o_px,
    output logic    o_frame_end,
    output logic    o_run_last
);

    logic r_has_a;
    logic r_has_b;
    logic r_fe;
    t_pix r_q_a;
    t_pix r_q_b;

    t_pix              q_a;
    t_pix              q_b;
    logic [PROD_W-1:0] prod_a;
    logic [PROD_W-1:0] prod_b;
    logic              take;

    always_comb begin
        q_a = '0;
        q_b = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            prod_a = PROD_W'(i_div.sum_a[k]) * PROD_W'(i_div.rcp_a);
            prod_b = PROD_W'(i_div.sum_b[k]) * PROD_W'(i_div.rcp_b);
            q_a[k] = prod_a[RECIP_SH +: CH_W];
            q_b[k] = prod_b[RECIP_SH +: CH_W];
        end
    end

    assign o_valid     = r_has_a || r_has_b;
    assign o_px        = r_has_a ? r_q_a : r_q_b;
    assign o_run_last  = !(r_has_a && r_has_b);
    assign o_frame_end = !r_has_a && r_fe;
    assign take        = o_valid && i_ready;
    // advance the pipe once the register empties or its last result leaves
    assign o_en        = !o_valid || (take && o_run_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_a <= 1'b0;
            r_has_b <= 1'b0;
        end else if (o_en) begin
            r_has_a <= i_div.a_en;
            r_has_b <= i_div.b_en;
        end else if (take) begin
            r_has_a <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_q_a <= q_a;
            r_q_b <= q_b;
            r_fe  <= i_div.frame_end;
        end
    end

endmodule

[hw/rtl/bb3c_chk.sv]
// Port-level checker for the clipped box filter and its bind to the top level.
module bb3c_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the bottom-right pixel is always the last result of its transaction
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("frame end on a result that is not the last of its run");

    // the first of a pair is followed at once by the second
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] |=> m_axis_tvalid)
        else $error("second result of a pair missing");

    // input is held back only by a waiting or unfinished output pair
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && (!m_axis_tready || !m_axis_tuser[0]))
        else $error("input stalled with no output pending");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind box_blur_3x3_clipped bb3c_chk u_bb3c_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

[dv/box_blur_3x3_clipped_tb.sv]
// Self-checking stream testbench of the clipped 3x3 box filter: random frames, idling and checks.
module box_blur_3x3_clipped_tb;
    import bb3c_pkg::*;

    localparam int MAX_DIM        = 1024;
    localparam int RANDOM_ITEMS   = 220;   // effective items in the random part
    localparam int BIG_TAIL       = 64;    // pixels of the second row in the large frame
    localparam int QUIET_LIMIT    = 3000;  // cycles without any transaction before giving up
    localparam int HOLDOFF_CYCLES = 400;   // long receiver hold-off in the large frame
    localparam int SETTLE_CYCLES  = 8;     // pipeline is four stages deep; leave some margin

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct {
        logic op;
        t_rgb px;
    } t_pixel_item;

    typedef struct {
        t_rgb px;
        logic frame_end;
        logic run_last;
    } t_blur_result;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [DIM_W-1:0] i_cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [47:0]      s_axis_tdata  = '0;  // red_in [15:0], green_in [31:16], blue_in [47:32]
    logic [0:0]       s_axis_tuser  = '0;  // op [0]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [47:0]      m_axis_tdata;        // red_out [15:0], green_out [31:16], blue_out [47:32]
    logic             m_axis_tlast;        // frame_end
    logic [0:0]       m_axis_tuser;        // run_last [0]

    box_blur_3x3_clipped #(
        .MAX_DIM(MAX_DIM)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Stimulus queue, expected means and run control
    t_pixel_item  pending_items[$];
    t_blur_result expected_means[$];
    t_pixel_item  next_item;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           err_count      = 0;
    int           quiet_cycles   = 0;
    int           hold_left      = 0;
    logic         holdoff_req    = 1'b0;
    logic         holdoff_done   = 1'b0;

    // Mirror of the filter state: frame size, line stores, 3x3 window, position counters
    logic [DIM_W-1:0] frame_dim = DIM_W'(512);
    t_rgb             line_above[MAX_DIM];
    t_rgb             line_mid[MAX_DIM];
    t_rgb             window_px[9];  // column-major: column * 3 + row, row 0 on top
    int               row_idx = 0;
    int               col_idx = 0;

    initial begin
        for (int k = 0; k < MAX_DIM; k++) begin
            line_above[k] = '0;
            line_mid[k]   = '0;
        end
        for (int k = 0; k < 9; k++) begin
            window_px[k] = '0;
        end
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Zero acts as one, anything above the store depth as the depth
    function automatic int eff_dim();
        if (frame_dim == '0) begin
            return 1;
        end
        if (int'(frame_dim) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(frame_dim);
    endfunction

    // Mean of the window taps around column centre that lie inside the frame
    function automatic t_rgb window_mean(input int centre, input bit left_ok, input bit right_ok,
                                         input bit top_ok, input bit bot_ok);
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int unsigned taps;
        int          lo;
        int          hi;
        int          c;
        int          r;
        t_rgb        m;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        taps  = 0;
        lo = left_ok ? centre - 1 : centre;
        hi = (right_ok && centre < 2) ? centre + 1 : centre;
        for (c = lo; c <= hi; c++) begin
            for (r = 0; r < 3; r++) begin
                if ((r == 0 && !top_ok) || (r == 2 && !bot_ok)) begin
                    continue;
                end
                sum_r += window_px[c * 3 + r].red;
                sum_g += window_px[c * 3 + r].green;
                sum_b += window_px[c * 3 + r].blue;
                taps++;
            end
        end
        if (taps == 0) begin
            taps = 1;
        end
        m.red   = CH_W'(sum_r / taps);
        m.green = CH_W'(sum_g / taps);
        m.blue  = CH_W'(sum_b / taps);
        return m;
    endfunction

    // Writing the size restarts the frame; stores and window keep their contents
    function automatic void set_frame_dim(input logic [DIM_W-1:0] v);
        frame_dim = v;
        row_idx   = 0;
        col_idx   = 0;
    endfunction

    // Advance the mirror by one accepted transaction and queue the means it yields
    task automatic predict_blur(input logic op, input t_rgb px_in);
        int           dim;
        int           idx;
        int           n;
        int           k;
        bit           drain;
        bit           draining;
        bit           top_ok;
        bit           bot_ok;
        t_rgb         above;
        t_rgb         mid;
        t_rgb         px;
        t_blur_result outs[2];
        dim      = eff_dim();
        drain    = (op == OP_DRAIN);
        draining = (row_idx >= dim);
        // drain inside the frame, or pixel while draining: drop it
        if (drain != draining) begin
            return;
        end
        idx   = (col_idx < MAX_DIM) ? col_idx : MAX_DIM - 1;
        px    = drain ? t_rgb'('0) : px_in;
        above = line_above[idx];
        mid   = line_mid[idx];
        for (k = 0; k < 6; k++) begin
            window_px[k] = window_px[k + 3];
        end
        window_px[6] = above;
        window_px[7] = mid;
        window_px[8] = px;
        if (!drain) begin
            line_above[idx] = mid;
            line_mid[idx]   = px;
        end
        if (row_idx >= 1) begin
            top_ok = (row_idx >= 2);
            bot_ok = !draining;
            n = 0;
            if (col_idx >= 1) begin
                outs[n].px        = window_mean(1, col_idx >= 2, 1'b1, top_ok, bot_ok);
                outs[n].frame_end = 1'b0;
                outs[n].run_last  = 1'b0;
                n++;
            end
            if (col_idx + 1 == dim) begin
                outs[n].px        = window_mean(2, col_idx >= 1, 1'b0, top_ok, bot_ok);
                outs[n].frame_end = draining;
                outs[n].run_last  = 1'b0;
                n++;
            end
            if (n > 0) begin
                outs[n - 1].run_last = 1'b1;
            end
            for (k = 0; k < n; k++) begin
                expected_means.push_back(outs[k]);
            end
        end
        if (col_idx + 1 >= dim) begin
            col_idx = 0;
            row_idx = draining ? 0 : row_idx + 1;
        end else begin
            col_idx = col_idx + 1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Compare one output transaction against the oldest expected mean
    task automatic check_mean();
        t_blur_result want;
        if (expected_means.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, data %h", m_axis_tdata));
            return;
        end
        want = expected_means.pop_front();
        if (m_axis_tdata[15:0] !== want.px.red) begin
            report_mismatch($sformatf("red_out %0d, want %0d", m_axis_tdata[15:0], want.px.red));
        end
        if (m_axis_tdata[31:16] !== want.px.green) begin
            report_mismatch($sformatf("green_out %0d, want %0d", m_axis_tdata[31:16],
                                      want.px.green));
        end
        if (m_axis_tdata[47:32] !== want.px.blue) begin
            report_mismatch($sformatf("blue_out %0d, want %0d", m_axis_tdata[47:32],
                                      want.px.blue));
        end
        if (m_axis_tlast !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, want %b", m_axis_tlast, want.frame_end));
        end
        if (m_axis_tuser[0] !== want.run_last) begin
            report_mismatch($sformatf("run_last %b, want %b", m_axis_tuser[0], want.run_last));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver, monitor and watchdog
    // ------------------------------------------------------------------

    // Hold tvalid until the transaction is taken; idle at random between transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_item.px.blue, next_item.px.green, next_item.px.red};
                s_axis_tuser  <= next_item.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall at random; once asked, hold off for a long stretch so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (holdoff_req && !holdoff_done) begin
            holdoff_done  <= 1'b1;
            hold_left     <= HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sample at the edge: register writes and input transactions feed the mirror,
    // output transactions are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_mean();
            end
            if (i_cfg_wr_en) begin
                set_frame_dim(i_cfg_wr_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_blur(s_axis_tuser[0], t_rgb'{red:   s_axis_tdata[15:0],
                                                     green: s_axis_tdata[31:16],
                                                     blue:  s_axis_tdata[47:32]});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Favour the channel extremes so full-scale sums turn up often
    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return CH_W'($urandom_range(65535));
            end
        endcase
    endfunction

    function automatic t_rgb rand_px();
        t_rgb p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        return p;
    endfunction

    task automatic push_item(input logic op, input t_rgb px);
        t_pixel_item it;
        it.op = op;
        it.px = px;
        pending_items.push_back(it);
    endtask

    // Queue one frame in raster order then its drain row; a noisy frame carries stray
    // transactions that the block drops, and now and then a frame is cut short
    task automatic queue_frame(input int dim, input bit noisy, inout int made, output bit broken);
        int total;
        int cut;
        int p;
        total  = dim * dim;
        broken = noisy && ($urandom_range(4) == 0);
        cut    = broken ? $urandom_range(total - 1) : total;
        for (p = 0; p < cut; p++) begin
            if (noisy && $urandom_range(31) == 0) begin
                push_item(OP_DRAIN, rand_px());
            end
            push_item(OP_PIXEL, rand_px());
            made++;
        end
        if (!broken) begin
            for (p = 0; p < dim; p++) begin
                if (noisy && $urandom_range(31) == 0) begin
                    push_item(OP_PIXEL, rand_px());
                end
                push_item(OP_DRAIN, rand_px());
                made++;
            end
        end
    endtask

    // Wait until every transaction is sent and every mean has come back, then let the
    // pipeline empty of transactions that yield nothing
    task automatic settle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_means.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dim(input int v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= DIM_W'(v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 74;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 74;
            end
            default: begin
                send_idle_pct  = 29;
                recv_stall_pct = 29;
            end
        endcase
    endtask

    initial begin
        int   made;
        int   phase;
        int   wr_dim;
        int   dim;
        int   frames;
        int   k;
        bit   broken;
        t_rgb full;
        t_rgb px;
        full = '1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One-pixel frame: a stray drain first, a stray pixel while draining
        write_dim(1);
        push_item(OP_DRAIN, full);
        push_item(OP_PIXEL, full);
        push_item(OP_PIXEL, '0);
        push_item(OP_DRAIN, '0);
        settle();

        // Size zero behaves as one
        write_dim(0);
        push_item(OP_PIXEL, t_rgb'{red: 16'h1234, green: 16'hFFFF, blue: 16'h0001});
        push_item(OP_DRAIN, full);
        settle();

        // Corners only, every tap at full scale
        write_dim(2);
        for (k = 0; k < 4; k++) begin
            push_item(OP_PIXEL, full);
        end
        push_item(OP_DRAIN, '0);
        push_item(OP_DRAIN, full);
        settle();

        // Corners, edges and the interior with alternating extremes
        write_dim(3);
        for (k = 0; k < 9; k++) begin
            px.red   = (k % 2) ? '1 : '0;
            px.green = (k % 2) ? '0 : '1;
            px.blue  = (k == 4) ? '1 : CH_W'(k);
            push_item(OP_PIXEL, px);
        end
        for (k = 0; k < 3; k++) begin
            push_item(OP_DRAIN, rand_px());
        end
        settle();

        // Random frames, mostly well formed and small, rotating through the idle phases
        made  = 0;
        phase = 0;
        while (made < RANDOM_ITEMS) begin
            set_idle(phase % 4);
            if ($urandom_range(15) == 0) begin
                wr_dim = 0;
            end else if ($urandom_range(7) == 0) begin
                wr_dim = $urandom_range(9, 16);
            end else begin
                wr_dim = $urandom_range(1, 6);
            end
            dim = (wr_dim == 0) ? 1 : wr_dim;
            write_dim(wr_dim);
            frames = $urandom_range(1, 2);
            for (k = 0; k < frames; k++) begin
                queue_frame(dim, $urandom_range(3) == 0, made, broken);
                if (broken) begin
                    break;
                end
            end
            settle();
            phase++;
        end

        // Oversized register value clamps to the store depth; send one full row and the
        // start of the next, and hold off the receiver once the second row is under way
        set_idle(0);
        write_dim(2047);
        for (k = 0; k < MAX_DIM + BIG_TAIL; k++) begin
            push_item(OP_PIXEL, rand_px());
        end
        while (pending_items.size() > BIG_TAIL / 2) begin
            @(posedge i_clk);
        end
        holdoff_req <= 1'b1;
        settle();

        // Largest legal size, a partial first row only
        write_dim(MAX_DIM);
        for (k = 0; k < 5; k++) begin
            push_item(OP_PIXEL, rand_px());
        end
        settle();

        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_means.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
